// File: sv/bps_pkg.sv
// Shared types and constants for the buzzer pattern sequencer.
// Used by every module of the block and by its checker; depends on nothing.
package bps_pkg;

  localparam int FREQ_W  = 15;
  localparam int DUR_W   = 32;
  localparam int IDX_W   = 2;
  localparam int PH3_W   = 12;  // phase within the 3000 ms continuous cycle
  localparam int PH1_W   = 10;  // phase within the 1000 ms locate cycle
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_PLAY      = 2'd1,
    OP_PLAY_CONT = 2'd2,
    OP_STOP      = 2'd3
  } op_t;

  // Pattern codes
  typedef enum logic [1:0] {
    PAT_SHORT  = 2'd0,
    PAT_LONG   = 2'd1,
    PAT_CONT   = 2'd2,
    PAT_LOCATE = 2'd3
  } pat_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_FREQ_WARNING    = 2'd0,
    REG_FREQ_BREACH     = 2'd1,
    REG_FREQ_CONTINUOUS = 2'd2,
    REG_UNUSED          = 2'd3
  } reg_idx_t;

  // Pattern timing in ms
  localparam logic [DUR_W-1:0] T_100  = 32'd100;
  localparam logic [DUR_W-1:0] T_200  = 32'd200;
  localparam logic [DUR_W-1:0] T_300  = 32'd300;
  localparam logic [DUR_W-1:0] T_500  = 32'd500;
  localparam logic [DUR_W-1:0] T_700  = 32'd700;
  localparam logic [DUR_W-1:0] T_1200 = 32'd1200;
  localparam logic [DUR_W-1:0] T_1400 = 32'd1400;
  localparam logic [DUR_W-1:0] T_1900 = 32'd1900;

  localparam logic [PH3_W-1:0] PH3_LAST = 12'd2999;
  localparam logic [PH3_W-1:0] PH3_ON   = 12'd2000;

  localparam logic [PH1_W-1:0] PH1_LAST = 10'd999;
  localparam logic [PH1_W-1:0] PH1_200  = 10'd200;
  localparam logic [PH1_W-1:0] PH1_300  = 10'd300;
  localparam logic [PH1_W-1:0] PH1_500  = 10'd500;
  localparam logic [PH1_W-1:0] PH1_600  = 10'd600;
  localparam logic [PH1_W-1:0] PH1_800  = 10'd800;

  // Locate chirp tones in Hz
  localparam logic [FREQ_W-1:0] HZ_2000 = 15'd2000;
  localparam logic [FREQ_W-1:0] HZ_3000 = 15'd3000;
  localparam logic [FREQ_W-1:0] HZ_4000 = 15'd4000;

  // Register reset values
  localparam logic [FREQ_W-1:0] RST_FREQ_WARNING    = 15'd2700;
  localparam logic [FREQ_W-1:0] RST_FREQ_BREACH     = 15'd3500;
  localparam logic [FREQ_W-1:0] RST_FREQ_CONTINUOUS = 15'd3000;

  // One input request
  typedef struct packed {
    logic [DUR_W-1:0] run_ms;
    pat_t             pattern;
    op_t              opcode;
  } item_t;

  // One result
  typedef struct packed {
    logic              playing;
    logic [FREQ_W-1:0] tone_freq;
    logic              tone_on;
  } res_t;

  // Tone frequency registers
  typedef struct packed {
    logic [FREQ_W-1:0] warning;
    logic [FREQ_W-1:0] breach;
    logic [FREQ_W-1:0] continuous;
  } freq_cfg_t;

endpackage

// File: sv/bps_in_stage.sv
// Input register of the buzzer pattern sequencer.
// Holds one accepted request until the engine takes it; uses bps_pkg.
module bps_in_stage import bps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  take,
  output logic                  item_vld,
  output item_t                 item
);

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  accept;

  // Free slot, or the held request leaves this cycle
  assign in_tready = !vld_r || take;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_t'(in_tdata[$bits(item_t)-1:0]);
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// File: sv/bps_cfg.sv
// Tone frequency registers of the buzzer pattern sequencer.
// Written through the cfg channel; uses bps_pkg.
module bps_cfg import bps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [FREQ_W-1:0] cfg_data,
  output freq_cfg_t         freqs
);

  freq_cfg_t freqs_r, freqs_nxt;

  assign cfg_ready = 1'b1;

  // Decode the write; an index past the list is dropped
  always_comb begin
    freqs_nxt = freqs_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FREQ_WARNING:    freqs_nxt.warning    = cfg_data;
        REG_FREQ_BREACH:     freqs_nxt.breach     = cfg_data;
        REG_FREQ_CONTINUOUS: freqs_nxt.continuous = cfg_data;
        default:             freqs_nxt            = freqs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freqs_r.warning    <= RST_FREQ_WARNING;
      freqs_r.breach     <= RST_FREQ_BREACH;
      freqs_r.continuous <= RST_FREQ_CONTINUOUS;
    end else begin
      freqs_r <= freqs_nxt;
    end
  end

  assign freqs = freqs_r;

endmodule

// File: sv/bps_engine.sv
// Pattern state and tone selection of the buzzer pattern sequencer.
// Updates its state once per request taken; uses bps_pkg.
module bps_engine import bps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  item_t     item,
  input  freq_cfg_t freqs,
  output res_t      res
);

  logic              active_r,  active_nxt;
  pat_t              pat_r,     pat_nxt;
  logic [DUR_W-1:0]  elapsed_r, elapsed_nxt;
  logic [DUR_W-1:0]  runlen_r,  runlen_nxt;
  logic [PH3_W-1:0]  ph3_r,     ph3_nxt;
  logic [PH1_W-1:0]  ph1_r,     ph1_nxt;
  logic              tone_r,    tone_nxt;
  logic [FREQ_W-1:0] hz_r,      hz_nxt;
  logic              expired;

  // Continuous and locate patterns end once past a nonzero run length
  assign expired = (runlen_r != '0) && (elapsed_r > runlen_r);

  // Next state for one request
  always_comb begin
    active_nxt  = active_r;
    pat_nxt     = pat_r;
    elapsed_nxt = elapsed_r;
    runlen_nxt  = runlen_r;
    ph3_nxt     = ph3_r;
    ph1_nxt     = ph1_r;
    tone_nxt    = tone_r;
    hz_nxt      = hz_r;
    unique case (item.opcode)
      OP_TICK: begin
        if (active_r) begin
          // Tone from the pattern at the current time
          tone_nxt = 1'b0;
          hz_nxt   = '0;
          unique case (pat_r)
            PAT_SHORT: begin
              priority if (elapsed_r < T_100) begin
                tone_nxt = 1'b1; hz_nxt = freqs.warning;
              end else if (elapsed_r < T_200) begin
                tone_nxt = 1'b0;
              end else if (elapsed_r < T_300) begin
                tone_nxt = 1'b1; hz_nxt = freqs.warning;
              end else begin
                active_nxt = 1'b0;
              end
            end
            PAT_LONG: begin
              priority if (elapsed_r < T_500) begin
                tone_nxt = 1'b1; hz_nxt = freqs.breach;
              end else if (elapsed_r < T_700) begin
                tone_nxt = 1'b0;
              end else if (elapsed_r < T_1200) begin
                tone_nxt = 1'b1; hz_nxt = freqs.breach;
              end else if (elapsed_r < T_1400) begin
                tone_nxt = 1'b0;
              end else if (elapsed_r < T_1900) begin
                tone_nxt = 1'b1; hz_nxt = freqs.breach;
              end else begin
                active_nxt = 1'b0;
              end
            end
            PAT_CONT: begin
              if (expired) begin
                active_nxt = 1'b0;
              end else if (ph3_r < PH3_ON) begin
                tone_nxt = 1'b1; hz_nxt = freqs.continuous;
              end
            end
            PAT_LOCATE: begin
              priority if (expired) begin
                active_nxt = 1'b0;
              end else if (ph1_r < PH1_200) begin
                tone_nxt = 1'b1; hz_nxt = HZ_2000;
              end else if (ph1_r < PH1_300) begin
                tone_nxt = 1'b0;
              end else if (ph1_r < PH1_500) begin
                tone_nxt = 1'b1; hz_nxt = HZ_3000;
              end else if (ph1_r < PH1_600) begin
                tone_nxt = 1'b0;
              end else if (ph1_r < PH1_800) begin
                tone_nxt = 1'b1; hz_nxt = HZ_4000;
              end else begin
                tone_nxt = 1'b0;
              end
            end
            default: active_nxt = active_r;
          endcase
          // Advance time; phases hold with elapsed once it saturates
          if (elapsed_r != '1) begin
            elapsed_nxt = elapsed_r + 1'b1;
            ph3_nxt     = (ph3_r == PH3_LAST) ? '0 : ph3_r + 1'b1;
            ph1_nxt     = (ph1_r == PH1_LAST) ? '0 : ph1_r + 1'b1;
          end
        end
      end
      OP_PLAY: begin
        pat_nxt     = item.pattern;
        elapsed_nxt = '0;
        ph3_nxt     = '0;
        ph1_nxt     = '0;
        active_nxt  = 1'b1;
      end
      OP_PLAY_CONT: begin
        pat_nxt     = PAT_CONT;
        elapsed_nxt = '0;
        ph3_nxt     = '0;
        ph1_nxt     = '0;
        runlen_nxt  = item.run_ms;
        active_nxt  = 1'b1;
      end
      OP_STOP: begin
        tone_nxt   = 1'b0;
        hz_nxt     = '0;
        active_nxt = 1'b0;
      end
      default: active_nxt = active_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      pat_r     <= PAT_SHORT;
      elapsed_r <= '0;
      runlen_r  <= '0;
      ph3_r     <= '0;
      ph1_r     <= '0;
      tone_r    <= 1'b0;
      hz_r      <= '0;
    end else if (take) begin
      active_r  <= active_nxt;
      pat_r     <= pat_nxt;
      elapsed_r <= elapsed_nxt;
      runlen_r  <= runlen_nxt;
      ph3_r     <= ph3_nxt;
      ph1_r     <= ph1_nxt;
      tone_r    <= tone_nxt;
      hz_r      <= hz_nxt;
    end
  end

  // Result as it stands after the request
  assign res.tone_on   = tone_nxt;
  assign res.tone_freq = tone_nxt ? hz_nxt : '0;
  assign res.playing   = active_nxt;

endmodule

// File: sv/bps_out_stage.sv
// Result register of the buzzer pattern sequencer.
// Holds one result until the sink takes it; uses bps_pkg.
module bps_out_stage import bps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  res_t                   res,
  output logic                   room,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic vld_r, vld_nxt;
  res_t res_r;

  // Empty, or the held result leaves this cycle
  assign room = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, res_r};

endmodule

// File: sv/buzzer_pattern_sequencer.sv
// Buzzer pattern sequencer: a request in and a result out every unstalled cycle.
// Path: input register, then pattern engine, then result register on out_.
// Throughput: one request per cycle while out_ is not stalled.
// Reset (rst_n low, synchronous): channels empty, pattern idle, tone off,
// tone frequency registers back to 2700 / 3500 / 3000 Hz.
module buzzer_pattern_sequencer import bps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // [1:0] opcode, [3:2] pattern, [35:4] run_ms, [39:36] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] tone_on, [15:1] tone_freq, [16] playing, [23:17] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [FREQ_W-1:0]      cfg_data
);

  item_t     item;
  logic      item_vld;
  logic      room;
  logic      take;
  res_t      res;
  freq_cfg_t freqs;

  // A request moves on when the result register can take its result
  assign take = item_vld && room;

  bps_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .item_vld  (item_vld),
    .item      (item)
  );

  bps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .freqs     (freqs)
  );

  bps_engine u_eng (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item),
    .freqs (freqs),
    .res   (res)
  );

  bps_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take),
    .res        (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: sv/bps_checker.sv
// Port-level checks for the buzzer pattern sequencer, bound to its top level.
// Uses bps_pkg for port widths.
module bps_checker import bps_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  // A stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("request changed while stalled");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Silent results report no frequency
  a_silent_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[15:1] == '0)
    else $error("frequency reported with tone off");

  // The tone only sounds while a pattern plays
  a_tone_playing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[16])
    else $error("tone on while not playing");

  // Nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind buzzer_pattern_sequencer bps_checker u_bps_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the buzzer pattern sequencer: stream requests in,
// tone results out, tone registers on the cfg_ channel, checked against an
// in-bench tone predictor. Depends on bps_pkg and buzzer_pattern_sequencer.
`timescale 1ns / 100ps

module tb_top;
  import bps_pkg::*;

  localparam int IN_PAD       = IN_TDATA_W - $bits(item_t);
  localparam int DRAIN_CYCLES = 8;     // drain margin after the last result
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int PHASE_REQS   = 420;   // random requests per idling phase

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [IDX_W-1:0]       cfg_index = '0;
  logic [FREQ_W-1:0]      cfg_data = '0;

  buzzer_pattern_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Request and result stores
  item_t req_q[$];
  res_t  tone_q[$];

  int n_queued   = 0;
  int n_accepted = 0;
  int n_ticks    = 0;
  int n_results  = 0;
  int n_finish   = 0;
  int n_cfg      = 0;
  int err_cnt    = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_go        = 1'b0;
  logic rx_hold      = 1'b0;

  // Tone predictor state
  logic [FREQ_W-1:0] hz_warning = RST_FREQ_WARNING;
  logic [FREQ_W-1:0] hz_breach  = RST_FREQ_BREACH;
  logic [FREQ_W-1:0] hz_cont    = RST_FREQ_CONTINUOUS;
  logic              play_on    = 1'b0;
  pat_t              cur_pat    = PAT_SHORT;
  logic [DUR_W-1:0]  ms_count   = '0;
  logic [DUR_W-1:0]  stop_after = '0;
  logic              buzz_en    = 1'b0;
  logic [FREQ_W-1:0] buzz_hz    = '0;

  // Apply one request to the predictor and return the tone it leaves behind
  function automatic res_t predict_tone(input item_t req);
    res_t              r;
    logic              on;
    logic              fin;
    logic [FREQ_W-1:0] hz;
    logic [DUR_W-1:0]  pos;
    case (req.opcode)
      OP_TICK: begin
        n_ticks++;
        if (play_on) begin
          on  = 1'b0;
          fin = 1'b0;
          hz  = '0;
          case (cur_pat)
            PAT_SHORT: begin
              on  = (ms_count < T_100) || (ms_count >= T_200 && ms_count < T_300);
              fin = (ms_count >= T_300);
              hz  = hz_warning;
            end
            PAT_LONG: begin
              on  = (ms_count < T_500) || (ms_count >= T_700 && ms_count < T_1200) ||
                    (ms_count >= T_1400 && ms_count < T_1900);
              fin = (ms_count >= T_1900);
              hz  = hz_breach;
            end
            PAT_CONT: begin
              fin = (stop_after != '0) && (ms_count > stop_after);
              on  = (ms_count % 3000) < 2000;
              hz  = hz_cont;
            end
            default: begin
              fin = (stop_after != '0) && (ms_count > stop_after);
              pos = ms_count % 1000;
              if (pos < 200) begin
                on = 1'b1;
                hz = HZ_2000;
              end else if (pos >= 300 && pos < 500) begin
                on = 1'b1;
                hz = HZ_3000;
              end else if (pos >= 600 && pos < 800) begin
                on = 1'b1;
                hz = HZ_4000;
              end
            end
          endcase
          if (fin) begin
            play_on = 1'b0;
            buzz_en = 1'b0;
            buzz_hz = '0;
            n_finish++;
          end else begin
            buzz_en = on;
            buzz_hz = on ? hz : '0;
          end
          // elapsed time saturates
          if (ms_count != '1) ms_count++;
        end
      end
      OP_PLAY: begin
        cur_pat  = req.pattern;
        ms_count = '0;
        play_on  = 1'b1;
      end
      OP_PLAY_CONT: begin
        cur_pat    = PAT_CONT;
        ms_count   = '0;
        stop_after = req.run_ms;
        play_on    = 1'b1;
      end
      default: begin
        play_on = 1'b0;
        buzz_en = 1'b0;
        buzz_hz = '0;
      end
    endcase
    r.tone_on   = buzz_en;
    r.tone_freq = buzz_en ? buzz_hz : '0;
    r.playing   = play_on;
    return r;
  endfunction

  function automatic void flag_result(input string what, input res_t want, input res_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t %s: expected on=%0d hz=%0d playing=%0d, got on=%0d hz=%0d playing=%0d",
               $time, what, want.tone_on, want.tone_freq, want.playing,
               got.tone_on, got.tone_freq, got.playing);
  endfunction

  // Request driver: predicts on acceptance, then offers the next pending request
  always @(posedge clk) begin : drive_req
    item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        tone_q.push_back(predict_tone(item_t'(in_tdata[$bits(item_t)-1:0])));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = req_q.pop_front();
          in_tdata  <= {{IN_PAD{1'b0}}, nxt};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : watch_res
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[$bits(res_t)-1:0]);
        n_results++;
        if (tone_q.size() == 0) begin
          flag_result("result with nothing pending", '0, got);
        end else begin
          want = tone_q.pop_front();
          if (got.tone_on !== want.tone_on || got.tone_freq !== want.tone_freq ||
              got.playing !== want.playing)
            flag_result("tone mismatch", want, got);
        end
      end
      out_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering
  initial begin : hold_off
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Run limit
  initial begin : run_limit
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void add_req(input op_t op, input pat_t pat, input logic [DUR_W-1:0] dur);
    item_t r;
    r.opcode  = op;
    r.pattern = pat;
    r.run_ms  = dur;
    req_q.push_back(r);
    n_queued++;
  endfunction

  // Ticks carry junk in the unused fields
  function automatic void add_ticks(input int n);
    for (int i = 0; i < n; i++) add_req(OP_TICK, pat_t'($urandom_range(3)), $urandom);
  endfunction

  function automatic logic [DUR_W-1:0] pick_run_length();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  // Mostly well-formed play-then-tick sequences, some noise; tick runs are
  // trimmed so that a phase stays close to its request budget
  task automatic queue_random(input int target);
    int base;
    int len;
    int left;
    base = n_queued;
    while (n_queued - base < target) begin
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 6))
          add_req(op_t'($urandom_range(3)), pat_t'($urandom_range(3)), $urandom);
      end else begin
        if ($urandom_range(1))
          add_req(OP_PLAY, pat_t'($urandom_range(3)), $urandom);
        else
          add_req(OP_PLAY_CONT, pat_t'($urandom_range(3)), pick_run_length());
        len  = ($urandom_range(5) == 0) ? $urandom_range(350, 1100) : $urandom_range(1, 350);
        left = target - (n_queued - base);
        if (len > left) len = left;
        for (int i = 0; i < len; i++) begin
          // occasional restart or stop mid-pattern
          if ($urandom_range(59) == 0)
            add_req(op_t'($urandom_range(1, 3)), pat_t'($urandom_range(3)), pick_run_length());
          else
            add_ticks(1);
        end
      end
    end
  endtask

  // Wait until every request is accepted and answered
  task automatic wait_idle();
    while (n_accepted != n_queued || tone_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all tone registers, plus the unused index with junk
  task automatic load_freqs(input logic [FREQ_W-1:0] w, input logic [FREQ_W-1:0] b,
                            input logic [FREQ_W-1:0] c);
    logic [FREQ_W-1:0] vals [4];
    vals = '{w, b, c, FREQ_W'($urandom)};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (reg_idx_t'(i))
        REG_FREQ_WARNING:    hz_warning = vals[i];
        REG_FREQ_BREACH:     hz_breach  = vals[i];
        REG_FREQ_CONTINUOUS: hz_cont    = vals[i];
        default: ;
      endcase
      n_cfg++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Stimulus sequence
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle stop/tick, short pattern, tiny and endless run lengths,
    // play keeping the old run length, stops, junk in unused fields
    add_req(OP_STOP, PAT_LOCATE, '1);
    add_req(OP_TICK, PAT_LOCATE, '1);
    add_req(OP_TICK, PAT_SHORT, '0);
    add_req(OP_PLAY, PAT_SHORT, '1);
    add_ticks(2);
    add_req(OP_PLAY_CONT, PAT_LOCATE, 32'd1);
    add_ticks(4);
    add_req(OP_PLAY, PAT_LOCATE, '0);
    add_ticks(3);
    add_req(OP_PLAY_CONT, PAT_SHORT, '1);
    add_ticks(1);
    add_req(OP_STOP, PAT_LONG, '0);
    add_ticks(1);
    add_req(OP_PLAY_CONT, PAT_CONT, '0);
    add_ticks(1);
    add_req(OP_PLAY, PAT_LONG, 32'h5555_AAAA);
    add_ticks(1);
    add_req(OP_STOP, PAT_SHORT, '0);
    add_req(OP_STOP, PAT_CONT, '1);
    wait_idle();

    // No idling, with a long output hold-off
    load_freqs(15'd20, 15'd20000, 15'h7FFF);
    set_idling(0, 0);
    queue_random(PHASE_REQS);
    hold_go = 1'b1;
    wait_idle();

    // Sender mostly idle
    load_freqs(15'd0, 15'h7FFF, 15'd20000);
    set_idling(88, 0);
    queue_random(PHASE_REQS);
    wait_idle();

    // Receiver mostly stalling
    load_freqs(FREQ_W'($urandom_range(20, 20000)), FREQ_W'($urandom_range(20, 20000)),
               FREQ_W'($urandom_range(20, 20000)));
    set_idling(0, 88);
    queue_random(PHASE_REQS);
    wait_idle();

    // Both sides idling
    load_freqs(15'd20000, 15'd20, 15'd20);
    set_idling(29, 29);
    queue_random(PHASE_REQS);
    wait_idle();

    err_cnt += tone_q.size();
    $display("Covered %0d requests (%0d ticks), %0d results checked, %0d pattern completions",
             n_accepted, n_ticks, n_results, n_finish);
    $display("%0d register writes across four idling phases and a %0d-cycle output hold-off",
             n_cfg, HOLD_CYCLES);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
